/* design/bwi_pkg.sv */
// Shared types and constants for the bicubic window interpolator.
// Holds the field widths, the coefficient reset value and the multiply-add control word.
// No dependencies.
package bwi_pkg;

    // Field widths of the ports.
    localparam int PIXEL_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int PHASE_W    = 8;
    localparam int ROW_W      = 2;
    localparam int KERNEL_A_W = 9;

    // Kernel coefficient a after reset: -0.5 in signed Q8.
    localparam logic signed [KERNEL_A_W-1:0] KERNEL_A_RESET = -9'sd128;

    // Control word from the sequencer to the shared multiply-add unit.
    typedef struct packed {
        logic issue;       // perform one multiply-add this cycle
        logic a_feedback;  // take the multiplicand from the accumulator
        logic c_feedback;  // take the addend from the accumulator
    } mac_ctl_t;

endpackage

/* design/bwi_mac.sv */
// Shared signed multiply-add unit with a registered result.
// Computes acc = a * b + c, where a and c may come back from acc itself.
// Depends on bwi_pkg for the control word.
module bwi_mac
    import bwi_pkg::*;
#(
    parameter int A_W = 32,
    parameter int B_W = 11,
    parameter int U_W = 44
)
(
    input  logic                  clk,
    input  mac_ctl_t              ctl,
    input  logic signed [A_W-1:0] a_op,
    input  logic signed [B_W-1:0] b_op,
    input  logic signed [U_W-1:0] c_op,
    output logic signed [U_W-1:0] acc
);

    localparam int M_W = A_W + B_W;
    localparam int F_W = (M_W > U_W) ? M_W : U_W;

    logic signed [U_W-1:0] acc_reg;
    logic signed [U_W-1:0] acc_next;
    logic signed [A_W-1:0] a_sel;
    logic signed [U_W-1:0] c_sel;
    logic signed [M_W-1:0] product;
    logic signed [F_W-1:0] full_sum;

    // Operand selection: the accumulator can feed either side for chained work.
    assign a_sel = ctl.a_feedback ? $signed(acc_reg[A_W-1:0]) : a_op;
    assign c_sel = ctl.c_feedback ? acc_reg : c_op;

    // One multiplication and one wide addition.
    assign product  = a_sel * b_op;
    assign full_sum = F_W'(product) + F_W'(c_sel);
    assign acc_next = ctl.issue ? $signed(full_sum[U_W-1:0]) : acc_reg;

    // Result register; it carries data only, so it needs no reset.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* design/bicubic_window_interpolator.sv */
// Top level of the bicubic window interpolator: sequencer, weight and sum storage.
// Depends on bwi_pkg and instantiates the shared multiply-add unit bwi_mac.
//
//  Channel   Signals                                        Direction
//  config    cfg_wr_en, cfg_wr_data                         in
//  input     in_valid, in_stall, pixel_0..3, phase_x,       in (in_stall out)
//            phase_y, window_row
//  output    out_valid, out_stall, out_red, out_green,      out (out_stall in)
//            out_blue
//
// Each input word is captured, then the five kernel weights are evaluated (three
// Horner steps and a rounding step each), the four 2-D weights are formed and twelve
// products are accumulated; a row 3 word then loads the result into the output word.
// Every product goes through the single multiply-add unit.
// Reset clears the sequencer, the output valid flag and the channel sums, and loads
// the default coefficient. in_stall stays high while a word is being worked on, and
// a row 3 word waits in its finishing state while a previous result is still stalled.
module bicubic_window_interpolator
    import bwi_pkg::*;
#(
    parameter int PHASE_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [KERNEL_A_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIXEL_W-1:0]    pixel_0,
    input  logic [PIXEL_W-1:0]    pixel_1,
    input  logic [PIXEL_W-1:0]    pixel_2,
    input  logic [PIXEL_W-1:0]    pixel_3,
    input  logic [PHASE_W-1:0]    phase_x,
    input  logic [PHASE_W-1:0]    phase_y,
    input  logic [ROW_W-1:0]      window_row,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_W-1:0]     out_red,
    output logic [CHAN_W-1:0]     out_green,
    output logic [CHAN_W-1:0]     out_blue
);

    localparam int P       = PHASE_BITS;
    localparam int PH_USED = (P < PHASE_W) ? P : PHASE_W;
    localparam int D_W     = P + 2;                        // distance, unsigned
    localparam int W_W     = P + 3;                        // tap weight, signed
    localparam int WC_W    = 2 * P + 4;                    // 2-D weight, signed
    localparam int A_W     = 2 * P + 16;                   // multiplicand
    localparam int B_W     = (P + 3 > CHAN_W + 1) ? P + 3 : CHAN_W + 1;
    localparam int SUM_W   = 2 * P + 28;                   // channel sums
    localparam int V_W     = 3 * P + 17;                   // kernel before rounding
    localparam int U_W     = (V_W > SUM_W) ? V_W : SUM_W;  // accumulator

    localparam logic [D_W-1:0] D_ONE = D_W'(1) << P;
    localparam logic [D_W-1:0] D_TWO = D_W'(2) << P;

    localparam logic signed [U_W-1:0]   W_HALF = U_W'(1) << (2 * P + 7);
    localparam logic signed [SUM_W:0]   R_HALF = (SUM_W + 1)'(1) << (2 * P - 1);

    localparam logic [2:0] WSEL_Y     = 3'd4;   // the vertical weight slot
    localparam logic [3:0] W_STORE    = 4'd3;   // rounding step of a weight
    localparam logic [3:0] COMB_LAST  = 4'd4;
    localparam logic [3:0] ACCUM_LAST = 4'd12;

    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_WEIGHT  = 5'b00010,
        ST_COMBINE = 5'b00100,
        ST_ACCUM   = 5'b01000,
        ST_FINISH  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic [2:0] wsel_reg;
    logic [2:0] wsel_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic signed [KERNEL_A_W-1:0] kernel_a_reg;

    logic [PIXEL_W-1:0]      pix_reg [4];
    logic [D_W-1:0]          tx_reg;
    logic [D_W-1:0]          ty_reg;
    logic [ROW_W-1:0]        row_reg;
    logic signed [W_W-1:0]   wx_reg [4];
    logic signed [W_W-1:0]   wy_reg;
    logic signed [WC_W-1:0]  wc_reg [4];
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CHAN_W-1:0]       red_reg;
    logic [CHAN_W-1:0]       green_reg;
    logic [CHAN_W-1:0]       blue_reg;

    logic                  in_accept;
    logic                  out_take;
    logic                  result_load;
    logic [1:0]            wtap;
    logic [D_W-1:0]        wt;
    logic [D_W-1:0]        tap_dist;
    logic                  outer;
    logic signed [11:0]    a_ext;
    logic signed [11:0]    c3;
    logic signed [11:0]    c2;
    logic signed [11:0]    c1;
    logic signed [11:0]    c0;
    logic [CHAN_W-1:0]     chan_val;
    logic signed [U_W-1:0] w_rnd;
    logic signed [U_W-1:0] w_shift;
    logic signed [W_W-1:0] w_new;

    mac_ctl_t              mac_ctl;
    logic signed [A_W-1:0] a_op;
    logic signed [B_W-1:0] b_op;
    logic signed [U_W-1:0] c_op;
    logic signed [U_W-1:0] acc;

    // Round a channel sum to nearest and saturate it to a byte.
    function automatic logic [CHAN_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0] r;
        begin
            r = (SUM_W + 1)'(s) + R_HALF;
            if (r[SUM_W])
            begin
                return '0;
            end
            else if (|r[SUM_W-1:2*P+CHAN_W])
            begin
                return '1;
            end
            else
            begin
                return r[2*P+CHAN_W-1:2*P];
            end
        end
    endfunction

    // Handshakes.
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_take    = out_valid_reg && !out_stall;
    assign result_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Which tap the current weight belongs to, and its distance from the sample.
    assign wtap = (wsel_reg == WSEL_Y) ? row_reg : wsel_reg[1:0];
    assign wt   = (wsel_reg == WSEL_Y) ? ty_reg : tx_reg;

    always_comb
    begin
        case (wtap)
            2'd0:
            begin
                tap_dist = D_ONE + wt;
                outer    = 1'b1;
            end
            2'd1:
            begin
                tap_dist = wt;
                outer    = 1'b0;
            end
            2'd2:
            begin
                tap_dist = D_ONE - wt;
                outer    = 1'b0;
            end
            default:
            begin
                tap_dist = D_TWO - wt;
                outer    = 1'b1;
            end
        endcase
    end

    // Polynomial coefficients of the kernel in Horner order.
    assign a_ext = 12'(kernel_a_reg);

    always_comb
    begin
        if (outer)
        begin
            c3 = a_ext;
            c2 = -(a_ext * 12'sd5);
            c1 = a_ext * 12'sd8;
            c0 = -(a_ext * 12'sd4);
        end
        else
        begin
            c3 = a_ext + 12'sd512;
            c2 = -(a_ext + 12'sd768);
            c1 = '0;
            c0 = 12'sd256;
        end
    end

    // Byte of the pixel for the current column and colour channel.
    always_comb
    begin
        case (step_reg[3:2])
            2'd0:    chan_val = pix_reg[step_reg[1:0]][23:16];
            2'd1:    chan_val = pix_reg[step_reg[1:0]][15:8];
            default: chan_val = pix_reg[step_reg[1:0]][7:0];
        endcase
    end

    // Operands for the shared unit in each phase of the work.
    always_comb
    begin
        mac_ctl = '0;
        a_op    = '0;
        b_op    = '0;
        c_op    = '0;
        case (state_reg)
            ST_WEIGHT:
            begin
                b_op = B_W'($signed({1'b0, tap_dist}));
                case (step_reg)
                    4'd0:
                    begin
                        mac_ctl.issue = 1'b1;
                        a_op = A_W'(c3);
                        c_op = U_W'(c2) <<< P;
                    end
                    4'd1:
                    begin
                        mac_ctl.issue      = 1'b1;
                        mac_ctl.a_feedback = 1'b1;
                        c_op = U_W'(c1) <<< (2 * P);
                    end
                    4'd2:
                    begin
                        mac_ctl.issue      = 1'b1;
                        mac_ctl.a_feedback = 1'b1;
                        c_op = U_W'(c0) <<< (3 * P);
                    end
                    default:
                    begin
                        mac_ctl = '0;
                    end
                endcase
            end
            ST_COMBINE:
            begin
                if (step_reg < COMB_LAST)
                begin
                    mac_ctl.issue = 1'b1;
                    a_op = A_W'(wx_reg[step_reg[1:0]]);
                    b_op = B_W'(wy_reg);
                end
            end
            ST_ACCUM:
            begin
                if (step_reg < ACCUM_LAST)
                begin
                    mac_ctl.issue = 1'b1;
                    a_op = A_W'(wc_reg[step_reg[1:0]]);
                    b_op = B_W'($signed({1'b0, chan_val}));
                    if (step_reg[1:0] == 2'd0)
                    begin
                        // A new channel starts from its sum, or from zero on row 0.
                        if (row_reg != ROW_FIRST)
                        begin
                            c_op = U_W'(sum_reg[step_reg[3:2]]);
                        end
                    end
                    else
                    begin
                        mac_ctl.c_feedback = 1'b1;
                    end
                end
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    bwi_mac #(
        .A_W (A_W),
        .B_W (B_W),
        .U_W (U_W)
    ) u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .a_op (a_op),
        .b_op (b_op),
        .c_op (c_op),
        .acc  (acc)
    );

    // Round the evaluated kernel to a weight in the phase format.
    assign w_rnd   = acc + W_HALF;
    assign w_shift = w_rnd >>> (2 * P + 8);
    assign w_new   = w_shift[W_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        wsel_next  = wsel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_WEIGHT;
                    step_next  = '0;
                    wsel_next  = '0;
                end
            end
            ST_WEIGHT:
            begin
                if (step_reg == W_STORE)
                begin
                    step_next = '0;
                    if (wsel_reg == WSEL_Y)
                    begin
                        state_next = ST_COMBINE;
                    end
                    else
                    begin
                        wsel_next = wsel_reg + 3'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_COMBINE:
            begin
                if (step_reg == COMB_LAST)
                begin
                    state_next = ST_ACCUM;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_ACCUM:
            begin
                if (step_reg == ACCUM_LAST)
                begin
                    step_next  = '0;
                    state_next = (row_reg == ROW_LAST) ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_FINISH:
            begin
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set on a new result, cleared when the word is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers, coefficient and channel sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            wsel_reg      <= '0;
            out_valid_reg <= 1'b0;
            kernel_a_reg  <= KERNEL_A_RESET;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            wsel_reg      <= wsel_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                kernel_a_reg <= $signed(cfg_wr_data);
            end
            // A channel's sum is written back as the next channel starts, or on the last accumulate step.
            if ((state_reg == ST_ACCUM) && (step_reg[1:0] == 2'd0) && (step_reg != '0))
            begin
                sum_reg[step_reg[3:2] - 2'd1] <= acc[SUM_W-1:0];
            end
        end
    end

    // Data registers: captured word, weights and the output word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pix_reg[0] <= pixel_0;
            pix_reg[1] <= pixel_1;
            pix_reg[2] <= pixel_2;
            pix_reg[3] <= pixel_3;
            tx_reg     <= D_W'(phase_x[PH_USED-1:0]);
            ty_reg     <= D_W'(phase_y[PH_USED-1:0]);
            row_reg    <= window_row;
        end
        if ((state_reg == ST_WEIGHT) && (step_reg == W_STORE))
        begin
            if (wsel_reg == WSEL_Y)
            begin
                wy_reg <= w_new;
            end
            else
            begin
                wx_reg[wsel_reg[1:0]] <= w_new;
            end
        end
        if ((state_reg == ST_COMBINE) && (step_reg != '0))
        begin
            wc_reg[2'(step_reg - 4'd1)] <= acc[WC_W-1:0];
        end
        if (result_load)
        begin
            red_reg   <= round_sat(sum_reg[0]);
            green_reg <= round_sat(sum_reg[1]);
            blue_reg  <= round_sat(sum_reg[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule
